@@ hw/rtl/nsc_pkg.sv @@
// Shared types and constants for the numeric constant scanner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package nsc_pkg;

  localparam int MAX_TOKEN_LENGTH_DEF = 255;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // ASCII codes the classifier looks for
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_POINT    = 8'h2E;
  localparam logic [7:0] CH_EXP_UP   = 8'h45;
  localparam logic [7:0] CH_EXP_LO   = 8'h65;
  localparam logic [7:0] CH_U        = 8'h75;
  localparam logic [7:0] CH_TYPE_D   = 8'h64;
  localparam logic [7:0] CH_TYPE_F   = 8'h66;
  localparam logic [7:0] CH_TYPE_LUP = 8'h4C;
  localparam logic [7:0] CH_TYPE_LLO = 8'h6C;
  localparam logic [7:0] CH_TYPE_I   = 8'h69;
  localparam logic [7:0] CH_TYPE_S   = 8'h73;
  localparam logic [7:0] CH_TYPE_C   = 8'h63;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DIGIT,
    CLS_SIGN,
    CLS_UNSIGNED,
    CLS_POINT,
    CLS_EXP,
    CLS_TYPE
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ hw/rtl/numeric_constant_scanner_unit.sv @@
// Channel  Dir  Word                      Sideband
// in_      in   tdata[7:0] char_code      tlast = last_char
// out_     out  tdata[7:0] token_length   tuser = is_constant
//
// One character word is taken per cycle while in_tready is high; the classifier and the rule engine
// are split by a four-word queue, so either side can stall on its own.
// A word is written into a queue slot when accepted and is judged from the queue head; the
// result for the word that ends the constant is registered in the output register (out_tvalid).
// in_tready drops only while the queue holds four words (out_tready held low).
// Reset (rst_n low, synchronous) empties the queue and clears all scan state.
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
`timescale 1ns / 1ps

module numeric_constant_scanner_unit
  import nsc_pkg::*;
#(
  parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] token_length
  output logic       out_tuser   // is_constant
);

  queue_status_t q_status;
  entry_t        push_entry;
  entry_t        head;
  logic          push;
  logic          pop;

  nsc_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  nsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  nsc_back #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // an invalid result always reports zero length
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'd0)
    else $error("invalid result with nonzero length");

  // a valid constant holds at least one digit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && (MAX_TOKEN_LENGTH < 256) |-> out_tdata != 8'd0)
    else $error("valid constant with zero length");

  // drain the queue only when the output register can take a word
  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !out_tvalid || out_tready)
    else $error("queue popped while output stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue status inconsistent");

endmodule

@@ hw/rtl/nsc_front.sv @@
// Front end: accepts input words and tags each character with its class.
// Depends on nsc_pkg; feeds nsc_queue.
`timescale 1ns / 1ps

module nsc_front
  import nsc_pkg::*;
(
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] char_code
  input  logic          in_tlast,   // last_char
  input  queue_status_t q_status,
  output logic          push,
  output entry_t        push_entry
);

  char_class_t cls;

  always_comb begin
    case (in_tdata) inside
      [CH_ZERO:CH_NINE]: cls = CLS_DIGIT;
      CH_PLUS, CH_MINUS: cls = CLS_SIGN;
      CH_U: cls = CLS_UNSIGNED;
      CH_POINT: cls = CLS_POINT;
      CH_EXP_UP, CH_EXP_LO: cls = CLS_EXP;
      CH_TYPE_D, CH_TYPE_F, CH_TYPE_LUP, CH_TYPE_LLO,
      CH_TYPE_I, CH_TYPE_S, CH_TYPE_C: cls = CLS_TYPE;
      default: cls = CLS_OTHER;
    endcase
  end

  assign in_tready       = !q_status.full;
  assign push            = in_tvalid && in_tready;
  assign push_entry.cls  = cls;
  assign push_entry.last = in_tlast;

endmodule

@@ hw/rtl/nsc_queue.sv @@
// Short queue of classified characters between front and back end.
// Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_queue
  import nsc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.full  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);

endmodule

@@ hw/rtl/nsc_back.sv @@
// Back end: applies the constant rules to classified characters and holds
// the result word in an output register. Depends on nsc_pkg.
`timescale 1ns / 1ps

module nsc_back
  import nsc_pkg::*;
#(
  parameter int MAX_TOKEN_LENGTH = MAX_TOKEN_LENGTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  entry_t        head,
  input  queue_status_t q_status,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,  // [7:0] token_length
  output logic          out_tuser   // is_constant
);

  localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic digit_r, digit_nxt;
  logic point_r, point_nxt;
  logic exp_r, exp_nxt;
  logic suffix_r, suffix_nxt;
  logic uns_ok_r, uns_ok_nxt;
  logic esign_ok_r, esign_ok_nxt;
  logic fin_r, fin_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_len_r, out_len_nxt;
  logic             out_const_r, out_const_nxt;

  logic             take, broken, over, acc, emit, valid;
  logic             digit_c, point_c, exp_c, suffix_c, nu, ne;
  logic [LEN_W-1:0] len_out;
  logic [LEN_W+7:0] len_ext;

  assign pop = !q_status.empty && (!out_valid_r || out_tready);

  always_comb begin
    take     = 1'b0;
    broken   = 1'b0;
    nu       = 1'b0;
    ne       = 1'b0;
    digit_c  = digit_r;
    point_c  = point_r;
    exp_c    = exp_r;
    suffix_c = suffix_r;

    if (esign_ok_r && head.cls == CLS_SIGN) begin
      take = 1'b1;
    end else if (uns_ok_r && head.cls == CLS_UNSIGNED) begin
      take = 1'b1;
    end else if (len_r == '0 && head.cls == CLS_SIGN) begin
      take = 1'b1;
    end else begin
      case (head.cls)
        CLS_DIGIT: begin
          digit_c = 1'b1;
          take    = 1'b1;
        end
        CLS_TYPE: begin
          if (!digit_r || suffix_r) begin
            broken = 1'b1;
          end else begin
            suffix_c = 1'b1;
            nu       = 1'b1;
            take     = 1'b1;
          end
        end
        CLS_POINT: begin
          if (point_r) begin
            broken = 1'b1;
          end else begin
            point_c = 1'b1;
            take    = 1'b1;
          end
        end
        CLS_EXP: begin
          if (exp_r || !digit_r) begin
            broken = 1'b1;
          end else begin
            exp_c = 1'b1;
            ne    = 1'b1;
            take  = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // one more character would push the constant past the bound
    over    = take && (len_r >= LEN_W'(MAX_TOKEN_LENGTH));
    acc     = take && !over;
    emit    = !acc || head.last;
    valid   = !(broken || over) && digit_c;
    len_out = acc ? len_r + 1'b1 : len_r;
    len_ext = {8'd0, len_out};

    len_nxt      = len_r;
    digit_nxt    = digit_r;
    point_nxt    = point_r;
    exp_nxt      = exp_r;
    suffix_nxt   = suffix_r;
    uns_ok_nxt   = uns_ok_r;
    esign_ok_nxt = esign_ok_r;
    fin_nxt      = fin_r;

    out_valid_nxt = out_valid_r && !out_tready;
    out_len_nxt   = out_len_r;
    out_const_nxt = out_const_r;

    if (pop) begin
      if (head.last) begin
        // string ends: clear for the next one
        len_nxt      = '0;
        digit_nxt    = 1'b0;
        point_nxt    = 1'b0;
        exp_nxt      = 1'b0;
        suffix_nxt   = 1'b0;
        uns_ok_nxt   = 1'b0;
        esign_ok_nxt = 1'b0;
        fin_nxt      = 1'b0;
      end else if (!fin_r) begin
        len_nxt    = len_out;
        digit_nxt  = digit_c;
        point_nxt  = point_c;
        exp_nxt    = exp_c;
        suffix_nxt = suffix_c;
        if (acc) begin
          uns_ok_nxt   = nu;
          esign_ok_nxt = ne;
        end
        fin_nxt = emit;
      end
      if (!fin_r && emit) begin
        out_valid_nxt = 1'b1;
        out_len_nxt   = valid ? len_ext[7:0] : 8'd0;
        out_const_nxt = valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      digit_r     <= 1'b0;
      point_r     <= 1'b0;
      exp_r       <= 1'b0;
      suffix_r    <= 1'b0;
      uns_ok_r    <= 1'b0;
      esign_ok_r  <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      digit_r     <= digit_nxt;
      point_r     <= point_nxt;
      exp_r       <= exp_nxt;
      suffix_r    <= suffix_nxt;
      uns_ok_r    <= uns_ok_nxt;
      esign_ok_r  <= esign_ok_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_len_r   <= out_len_nxt;
    out_const_r <= out_const_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_len_r;
  assign out_tuser  = out_const_r;

endmodule
